@@ hw/rtl/chkv_pkg.sv @@
// ----------------------------------------------------------------------------
// chkv_pkg
// Shared sizes, codes and types of the chained hash key-value store.
// ----------------------------------------------------------------------------
package chkv_pkg;

	localparam int NUM_BUCKETS  = 10;
	localparam int BUCKET_SLOTS = 8;
	localparam int TOTAL_SLOTS  = NUM_BUCKETS * BUCKET_SLOTS;

	localparam int KIND_W   = 2;
	localparam int KEY_W    = 31;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;

	localparam int SLOT_W  = $clog2(TOTAL_SLOTS);
	localparam int CNT_W   = $clog2(TOTAL_SLOTS + 1);
	localparam int REM_W   = $clog2(NUM_BUCKETS);
	localparam int SCNT_W  = $clog2(BUCKET_SLOTS + 1);

	// The bucket index is found by multiplying with the rounded-up reciprocal
	// of the bucket count; with this shift the quotient is exact for any key.
	localparam int MOD_SHIFT = KEY_W + $clog2(NUM_BUCKETS);
	localparam int RECIP_W   = KEY_W + 1;
	localparam int PROD_W    = KEY_W + RECIP_W;
	localparam int QUO_W     = PROD_W - MOD_SHIFT;
	localparam logic [RECIP_W-1:0] MOD_RECIP = RECIP_W'(
		((64'd1 << MOD_SHIFT) + 64'(NUM_BUCKETS - 1)) / 64'(NUM_BUCKETS));

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

	// Response of the remainder unit to the sequencer.
	typedef struct packed {
		logic             done;
		logic [REM_W-1:0] rem;
	} chkv_mod_rsp_t;

endpackage

@@ hw/rtl/chkv_mod.sv @@
// ----------------------------------------------------------------------------
// chkv_mod
// Remainder of a key by the bucket count in two steps: a multiply by the
// reciprocal gives the quotient, then the quotient times the count is
// subtracted from the key.
// ----------------------------------------------------------------------------
module chkv_mod import chkv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	output chkv_mod_rsp_t    rsp
);

	logic [KEY_W-1:0]  key_q;
	logic [QUO_W-1:0]  quo_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_q;
	logic [PROD_W-1:0] prod;
	logic [KEY_W-1:0]  rem_full;

	assign prod     = PROD_W'(key) * PROD_W'(MOD_RECIP);
	// The true remainder is small, so the difference is exact at key width.
	assign rem_full = key_q - KEY_W'(quo_q) * KEY_W'(NUM_BUCKETS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			quo_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rem_q  <= '0;
		end else if (start) begin
			key_q  <= key;
			quo_q  <= prod[PROD_W-1:MOD_SHIFT];
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= rem_full[REM_W-1:0];
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

@@ hw/rtl/chkv_mem.sv @@
// ----------------------------------------------------------------------------
// chkv_mem
// Slot storage for keys and values: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module chkv_mem import chkv_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [SLOT_W-1:0] waddr,
	input  logic [KEY_W-1:0]  wkey,
	input  logic [DATA_W-1:0] wval,
	input  logic [SLOT_W-1:0] raddr,
	output logic [KEY_W-1:0]  rkey,
	output logic [DATA_W-1:0] rval
);

	logic [KEY_W-1:0]  key_mem [TOTAL_SLOTS];
	logic [DATA_W-1:0] val_mem [TOTAL_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			val_mem[waddr] <= wval;
		end
		rkey <= key_mem[raddr];
		rval <= val_mem[raddr];
	end

endmodule

@@ hw/rtl/chained_hash_key_value_store.sv @@
// ----------------------------------------------------------------------------
// chained_hash_key_value_store
// Steps from an accepted request word to its result word: the quotient and
// then the remainder of the key are formed, the bucket base is set, eight
// slot reads are issued one per cycle, the last slot's key is compared, and
// the store is updated. One request is handled at a time; a held result
// word holds the finish step and so the input.
// Reset: all slots become free and the entry count is zero at once.
// ----------------------------------------------------------------------------
module chained_hash_key_value_store import chkv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [KEY_W-1:0]    key,
	input  logic [DATA_W-1:0]   data_word,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [DATA_W-1:0]   read_value,
	output logic                table_empty
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t               state_q;
	logic [KIND_W-1:0]    kind_q;
	logic [KEY_W-1:0]     key_q;
	logic [DATA_W-1:0]    data_q;
	logic [SLOT_W-1:0]    base_q;
	logic [SCNT_W-1:0]    issue_q;
	logic                 hit_q;
	logic [SLOT_W-1:0]    hit_idx_q;
	logic [DATA_W-1:0]    hit_val_q;
	logic                 free_q;
	logic [SLOT_W-1:0]    free_idx_q;
	logic [TOTAL_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [DATA_W-1:0]    read_value_q;
	logic                 empty_q;

	logic                 chk_s1;
	logic [SLOT_W-1:0]    idx_s1;

	logic                 accept;
	logic                 out_free;
	chkv_mod_rsp_t        mod_rsp;
	logic [SLOT_W-1:0]    rd_addr;
	logic [KEY_W-1:0]     rd_key;
	logic [DATA_W-1:0]    rd_val;
	logic                 issue;

	logic                 wr_en;
	logic [SLOT_W-1:0]    wr_idx;
	logic                 set_v;
	logic                 clr_v;
	logic [CNT_W-1:0]     cnt_nxt;
	logic [STATUS_W-1:0]  st_nxt;
	logic [DATA_W-1:0]    val_nxt;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign issue    = (state_q == S_SCAN) && (issue_q < SCNT_W'(BUCKET_SLOTS));
	assign rd_addr  = base_q + SLOT_W'(issue_q);

	chkv_mod u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.key   (key),
		.rsp   (mod_rsp)
	);

	chkv_mem u_mem (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_idx),
		.wkey (key_q),
		.wval (data_q),
		.raddr(rd_addr),
		.rkey (rd_key),
		.rval (rd_val)
	);

	// Store update and result of the request, applied in the finish cycle.
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = hit_idx_q;
		set_v   = 1'b0;
		clr_v   = 1'b0;
		cnt_nxt = cnt_q;
		st_nxt  = ST_NOT_FOUND;
		val_nxt = '0;
		case (kind_q)
			KIND_INSERT: begin
				if (hit_q) begin
					wr_en  = 1'b1;
					st_nxt = ST_REPLACED;
				end else if (free_q) begin
					wr_en   = 1'b1;
					wr_idx  = free_idx_q;
					set_v   = 1'b1;
					cnt_nxt = cnt_q + 1'b1;
					st_nxt  = ST_ADDED;
				end else begin
					st_nxt = ST_FULL;
				end
			end
			KIND_REMOVE: begin
				if (hit_q) begin
					clr_v   = 1'b1;
					cnt_nxt = cnt_q - 1'b1;
					st_nxt  = ST_REMOVED;
				end
			end
			KIND_SEARCH: begin
				if (hit_q) begin
					st_nxt  = ST_FOUND;
					val_nxt = hit_val_q;
				end
			end
			default: begin
				st_nxt = ST_NOT_FOUND;
			end
		endcase
		if (state_q != S_FINISH || !out_free) begin
			wr_en   = 1'b0;
			set_v   = 1'b0;
			clr_v   = 1'b0;
			cnt_nxt = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= '0;
			key_q        <= '0;
			data_q       <= '0;
			base_q       <= '0;
			issue_q      <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			hit_val_q    <= '0;
			free_q       <= 1'b0;
			free_idx_q   <= '0;
			valid_q      <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_NOT_FOUND;
			read_value_q <= '0;
			empty_q      <= 1'b1;
			chk_s1       <= 1'b0;
			idx_s1       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// One slot read is issued per cycle; its key is compared in the next cycle.
			chk_s1 <= issue;
			idx_s1 <= rd_addr;
			if (chk_s1) begin
				if (valid_q[idx_s1] && rd_key == key_q && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_s1;
					hit_val_q <= rd_val;
				end
				if (!valid_q[idx_s1] && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q  <= kind;
						key_q   <= key;
						data_q  <= data_word;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_rsp.done) begin
						base_q  <= SLOT_W'(mod_rsp.rem) * SLOT_W'(BUCKET_SLOTS);
						issue_q <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						issue_q <= issue_q + 1'b1;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						if (set_v) begin
							valid_q[wr_idx] <= 1'b1;
						end
						if (clr_v) begin
							valid_q[hit_idx_q] <= 1'b0;
						end
						cnt_q        <= cnt_nxt;
						status_q     <= st_nxt;
						read_value_q <= val_nxt;
						empty_q      <= (cnt_nxt == '0);
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign table_empty = empty_q;

	// The entry count always equals the number of occupied slots.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(cnt_q))
		else $error("entry count differs from occupied slots");

	a_added_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ADDED |-> !table_empty)
		else $error("store reported empty after an add");

	a_value_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_FOUND |-> read_value == '0)
		else $error("read value nonzero without a found search");

	a_result_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FINISH)
		else $error("result word loaded outside the finish step");

endmodule

@@ bench/chained_hash_key_value_store_test.sv @@
// ----------------------------------------------------------------------------
// chained_hash_key_value_store_test
// Sends insert, remove and search words into the hash key-value store and
// compares every result word with a shadow copy of the table kept here.
// The sender and the receiver idle at random and the output is held off at
// times.
// ----------------------------------------------------------------------------
module chained_hash_key_value_store_test import chkv_pkg::*; ();

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_WORDS  = 1400;
	localparam int PHASE_WORDS   = 200;
	localparam int SETTLE_CYCLES = 60;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   value;
		logic                empty;
	} reply_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [KIND_W-1:0]   kind;
	logic [KEY_W-1:0]    key;
	logic [DATA_W-1:0]   data_word;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   read_value;
	logic                table_empty;

	// Shadow copy of the store, laid out bucket by bucket.
	logic [KEY_W-1:0]  shadow_key [TOTAL_SLOTS];
	logic [DATA_W-1:0] shadow_value [TOTAL_SLOTS];
	bit                shadow_used [TOTAL_SLOTS];
	int                shadow_count;

	reply_t pending_replies[$];
	logic [KEY_W-1:0] wide_keys[$];
	int  err_count;
	int  hold_request;
	bit  steady_flow;

	chained_hash_key_value_store uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.key         (key),
		.data_word   (data_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_value  (read_value),
		.table_empty (table_empty)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Applies one request to the shadow table and returns the result it causes.
	function automatic reply_t apply_request(input logic [KIND_W-1:0] k,
			input logic [KEY_W-1:0] ky, input logic [DATA_W-1:0] d);
		reply_t r;
		int     base;
		int     hit;
		int     free;
		r.status = ST_NOT_FOUND;
		r.value  = '0;
		base = int'(ky % NUM_BUCKETS) * BUCKET_SLOTS;
		hit  = -1;
		free = -1;
		for (int s = 0; s < BUCKET_SLOTS; s++) begin
			if (shadow_used[base + s] && shadow_key[base + s] == ky && hit < 0)
				hit = base + s;
			if (!shadow_used[base + s] && free < 0)
				free = base + s;
		end
		case (k)
			KIND_INSERT: begin
				if (hit >= 0) begin
					shadow_value[hit] = d;
					r.status = ST_REPLACED;
				end else if (free >= 0) begin
					shadow_used[free]  = 1'b1;
					shadow_key[free]   = ky;
					shadow_value[free] = d;
					shadow_count++;
					r.status = ST_ADDED;
				end else begin
					r.status = ST_FULL;
				end
			end
			KIND_REMOVE: begin
				if (hit >= 0) begin
					shadow_used[hit] = 1'b0;
					shadow_count--;
					r.status = ST_REMOVED;
				end
			end
			KIND_SEARCH: begin
				if (hit >= 0) begin
					r.value  = shadow_value[hit];
					r.status = ST_FOUND;
				end
			end
			default: ;
		endcase
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Keys that crowd three buckets, so chains fill up and overflow.
	function automatic logic [KEY_W-1:0] pool_key();
		int lane;
		case ($urandom_range(0, 2))
			0: lane = 0;
			1: lane = 1;
			default: lane = 7;
		endcase
		return KEY_W'(10 * $urandom_range(0, 11) + lane);
	endfunction

	function automatic logic [DATA_W-1:0] random_data();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		else if (r < 10)
			return '1;
		return $urandom;
	endfunction

	task automatic send_word(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] ky,
			input logic [DATA_W-1:0] d);
		int gap;
		gap = steady_flow ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		kind      = k;
		key       = ky;
		data_word = d;
		do @(posedge clk); while (in_stall);
		pending_replies.push_back(apply_request(k, ky, d));
	endtask

	task automatic wait_all_replies();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_table_ops();
		send_word(KIND_SEARCH, '0, 32'h1234_5678);
		send_word(KIND_REMOVE, 31'd5, '1);
		send_word(KIND_INSERT, '0, '0);
		send_word(KIND_INSERT, '1, '1);
		send_word(KIND_SEARCH, '1, '0);
		send_word(KIND_INSERT, '0, '1);
		send_word(KIND_SEARCH, '0, 32'h5555_AAAA);
		send_word(KIND_REMOVE, '0, '1);
		send_word(KIND_REMOVE, '0, '0);
		send_word(KIND_REMOVE, '1, 32'hAAAA_5555);
	endtask

	task automatic test_unused_kind();
		send_word(KIND_UNUSED, 31'd10, 32'h0000_1234);
		send_word(KIND_INSERT, 31'd3, 32'hCAFE_0003);
		send_word(KIND_UNUSED, 31'd3, 32'hFFFF_0000);
		send_word(KIND_SEARCH, 31'd3, '0);
	endtask

	// Fills bucket 7, overflows it, replaces a key inside the full bucket, then searches for it and the overflowed key.
	task automatic test_bucket_overflow();
		for (int i = 0; i <= BUCKET_SLOTS; i++)
			send_word(KIND_INSERT, KEY_W'(10 * i + 7), DATA_W'(32'h7000_0000 + i));
		send_word(KIND_INSERT, 31'd47, 32'hDEAD_BEEF);
		send_word(KIND_SEARCH, 31'd47, '0);
		send_word(KIND_SEARCH, KEY_W'(10 * BUCKET_SLOTS + 7), '0);
	endtask

	// The receiver holds off while words keep coming, so the input stalls.
	task automatic test_output_hold();
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 6; i++)
			send_word(KIND_SEARCH, pool_key(), random_data());
		wait_all_replies();
	endtask

	task automatic test_random_traffic();
		int r;
		bit draining;
		logic [KIND_W-1:0] k;
		logic [KEY_W-1:0]  ky;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// Fill phases alternate with drain phases so the table empties now and then.
			draining    = ((n / PHASE_WORDS) % 2 == 1);
			steady_flow = ((n / PHASE_WORDS) % 3 == 2);
			r = $urandom_range(0, 99);
			if (draining)
				k = (r < 15) ? KIND_INSERT : (r < 75) ? KIND_REMOVE :
					(r < 97) ? KIND_SEARCH : KIND_UNUSED;
			else
				k = (r < 55) ? KIND_INSERT : (r < 70) ? KIND_REMOVE :
					(r < 97) ? KIND_SEARCH : KIND_UNUSED;
			r = $urandom_range(0, 99);
			if (r < 85) begin
				ky = pool_key();
			end else if (draining && k == KIND_REMOVE && wide_keys.size() > 0) begin
				ky = wide_keys.pop_front();
			end else begin
				ky = KEY_W'($urandom);
				if (k == KIND_INSERT)
					wide_keys.push_back(ky);
			end
			send_word(k, ky, random_data());
		end
		steady_flow = 1'b0;
	endtask

	// Receiver: random stalls, plus a long hold-off when one is requested.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
				if (!steady_flow)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		reply_t exp;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				$error("result word with no request outstanding: status %0d", status);
				err_count++;
			end else begin
				exp = pending_replies.pop_front();
				if (status !== exp.status) begin
					$error("status mismatch: expected %0d, actual %0d", exp.status, status);
					err_count++;
				end
				if (read_value !== exp.value) begin
					$error("read_value mismatch: expected %h, actual %h", exp.value,
						read_value);
					err_count++;
				end
				if (table_empty !== exp.empty) begin
					$error("table_empty mismatch: expected %0d, actual %0d", exp.empty,
						table_empty);
					err_count++;
				end
			end
		end
	end

	initial begin
		err_count    = 0;
		hold_request = 0;
		steady_flow  = 1'b0;
		shadow_count = 0;
		in_valid     = 1'b0;
		kind         = KIND_INSERT;
		key          = '0;
		data_word    = '0;
		arst_n       = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table_ops();
		test_unused_kind();
		test_bucket_overflow();
		wait_all_replies();
		test_output_hold();
		test_random_traffic();
		wait_all_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
